// File: sv/mhpq_pkg.sv
// ---------------------------------------------------------------------------
// mhpq_pkg: shared definitions of the max-heap priority queue
// Holds the default sizes, the beat layout and the request and status codes.
// ---------------------------------------------------------------------------
package mhpq_pkg;

  // Default sizes of the heap storage.
  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // Field widths of the request and response beats.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned RESULT_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Request beat layout, lowest bit first.
  localparam int unsigned IN_ACTION_LSB = 0;
  localparam int unsigned IN_VALUE_LSB  = IN_ACTION_LSB + ACTION_W;
  localparam int unsigned IN_SLOT_LSB   = IN_VALUE_LSB + VALUE_W;
  localparam int unsigned IN_FIELDS_W   = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // Response beat layout, lowest bit first.
  localparam int unsigned OUT_RESULT_LSB = 0;
  localparam int unsigned OUT_STATUS_LSB = OUT_RESULT_LSB + RESULT_W;
  localparam int unsigned OUT_COUNT_LSB  = OUT_STATUS_LSB + STATUS_W;
  localparam int unsigned OUT_FIELDS_W   = OUT_COUNT_LSB + COUNT_W;
  localparam int unsigned OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_PEEK   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CHANGE = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

// File: sv/max_heap_priority_queue_core.sv
// ---------------------------------------------------------------------------
// max_heap_priority_queue_core: binary max-heap priority queue
// Insert, peek, remove-maximum and change-at-index on a heap kept in one
// on-chip memory, walked level by level by a small sequencer.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents (lowest bit first)
//  -------  ---------  ------------------------------------------------------
//  s_axis   in         action[1:0], value[33:2], slot[39:34]
//  m_axis   out        result_value[31:0], status[33:32], entry_count[40:34]
//
// One request is in flight at a time; s_axis_tready is high only while the
// sequencer is idle. Every sift step first reads the neighbor entries from
// the heap memory (registered read data), then compares and writes back, so
// the memory read latency sets the pace.
// Reset clears the entry count and the sequencer; the memory is not cleared,
// since only entries below the count are ever used. A stalled response waits
// in the output register while the next request is already taken.
module max_heap_priority_queue_core #(
  parameter int unsigned CAPACITY   = mhpq_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = mhpq_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request: action[1:0], value[33:2], slot[39:34]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mhpq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Response: result_value[31:0], status[33:32], entry_count[40:34], zero pad
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mhpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mhpq_pkg::*;

  // Address, count and child index widths follow from the capacity.
  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CIW   = AW + 2;
  localparam int unsigned CMP_W = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int unsigned XCW   = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned XW    = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int unsigned PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FETCH  = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_UP_RD  = 8'b0000_1000,
    S_UP_CMP = 8'b0001_0000,
    S_DN_RD  = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e                  state_q, state_d;
  action_e                 act_q, act_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [DATA_WIDTH-1:0]   cur_q, cur_d;
  logic [DATA_WIDTH-1:0]   res_q, res_d;
  status_e                 sts_q, sts_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]  out_data_q, out_data_d;

  // Heap memory: one write port, two registered read ports.
  logic [DATA_WIDTH-1:0]   heap_mem [CAPACITY];
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [DATA_WIDTH-1:0]   mem_wdata;
  logic [AW-1:0]           rd_a_addr, rd_b_addr;
  logic [DATA_WIDTH-1:0]   rd_a_q, rd_b_q;

  // Request fields.
  action_e                 in_action;
  logic [VALUE_W-1:0]      in_value;
  logic [SLOT_W-1:0]       in_slot;
  logic [XW-1:0]           value_x;
  logic [DATA_WIDTH-1:0]   value_w;
  logic                    accept;

  // Derived control.
  logic                    is_full, is_empty, slot_ok;
  logic [AW-1:0]           parent_idx, last_idx;
  logic [CIW-1:0]          left_x, right_x, cnt_ci;
  logic                    left_ok, right_ok, pick_right, swap_dn;
  logic [DATA_WIDTH-1:0]   child_val;
  logic [AW-1:0]           child_idx;
  logic [XW-1:0]           res_x;
  logic [XCW-1:0]          cnt_x;

  assign in_action = action_e'(s_axis_tdata[IN_VALUE_LSB-1:IN_ACTION_LSB]);
  assign in_value  = s_axis_tdata[IN_SLOT_LSB-1:IN_VALUE_LSB];
  assign in_slot   = s_axis_tdata[IN_FIELDS_W-1:IN_SLOT_LSB];
  // Only the low DATA_WIDTH bits of the value are kept.
  assign value_x   = XW'(in_value);
  assign value_w   = value_x[DATA_WIDTH-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_full    = (cnt_q == CW'(CAPACITY));
  assign is_empty   = (cnt_q == '0);
  assign slot_ok    = (CMP_W'(in_slot) < CMP_W'(cnt_q));
  assign parent_idx = AW'((pos_q - AW'(1)) >> 1);
  assign last_idx   = AW'(cnt_q - CW'(1));

  // Children of the current position; the right child is only taken when
  // strictly larger, so the left child wins a tie.
  assign left_x     = (CIW'(pos_q) << 1) + CIW'(1);
  assign right_x    = left_x + CIW'(1);
  assign cnt_ci     = CIW'(cnt_q);
  assign left_ok    = (left_x < cnt_ci);
  assign right_ok   = (right_x < cnt_ci);
  assign pick_right = right_ok && (rd_b_q > rd_a_q);
  assign child_val  = pick_right ? rd_b_q : rd_a_q;
  assign child_idx  = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];
  assign swap_dn    = left_ok && (child_val > cur_q);

  assign res_x = XW'(res_q);
  assign cnt_x = XCW'(cnt_q);

  // Read addresses depend on the sequencer state, action, position and count.
  always_comb begin
    rd_a_addr = left_x[AW-1:0];
    rd_b_addr = right_x[AW-1:0];
    if (state_q == S_FETCH) begin
      rd_a_addr = (act_q == ACT_CHANGE) ? pos_q : '0;
      rd_b_addr = last_idx;
    end else if (state_q == S_UP_RD) begin
      rd_a_addr = parent_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  // Sequencer. The moving entry stays in cur_q; displaced entries are
  // written into the hole, and cur_q lands where the walk stops.
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    res_d       = res_q;
    sts_d       = sts_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d = in_action;
          res_d = '0;
          sts_d = ST_OK;
          cur_d = value_w;
          unique case (in_action)
            ACT_INSERT: begin
              if (is_full) begin
                sts_d   = ST_FULL;
                state_d = S_DONE;
              end else begin
                pos_d   = cnt_q[AW-1:0];
                cnt_d   = cnt_q + CW'(1);
                state_d = S_UP_RD;
              end
            end
            ACT_PEEK, ACT_REMOVE: begin
              if (is_empty) begin
                sts_d   = ST_EMPTY;
                state_d = S_DONE;
              end else begin
                state_d = S_FETCH;
              end
            end
            ACT_CHANGE: begin
              if (!slot_ok) begin
                sts_d   = ST_RANGE;
                state_d = S_DONE;
              end else begin
                pos_d   = AW'(in_slot);
                state_d = S_FETCH;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_FETCH: state_d = S_DECIDE;

      S_DECIDE: begin
        unique case (act_q)
          ACT_PEEK: begin
            res_d   = rd_a_q;
            state_d = S_DONE;
          end
          ACT_REMOVE: begin
            // Root goes out, last entry starts its walk down from the root.
            res_d   = rd_a_q;
            cur_d   = rd_b_q;
            cnt_d   = cnt_q - CW'(1);
            pos_d   = '0;
            state_d = S_DN_RD;
          end
          ACT_CHANGE: begin
            state_d = (cur_q > rd_a_q) ? S_UP_RD : S_DN_RD;
          end
          default: state_d = S_DONE;
        endcase
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_a_q < cur_q) begin
          mem_wdata = rd_a_q;
          pos_d     = parent_idx;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DN_RD: state_d = S_DN_CMP;

      S_DN_CMP: begin
        mem_we = 1'b1;
        if (swap_dn) begin
          mem_wdata = child_val;
          pos_d     = child_idx;
          state_d   = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {{PAD_W{1'b0}}, cnt_x[COUNT_W-1:0], sts_q, res_x[RESULT_W-1:0]};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    pos_q      <= pos_d;
    cur_q      <= cur_d;
    res_q      <= res_d;
    sts_q      <= sts_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/mhpq_checker.sv
// ---------------------------------------------------------------------------
// mhpq_checker: port-level checks of the max-heap priority queue
// Watches the request and response beats and flags impossible responses.
// ---------------------------------------------------------------------------
module mhpq_checker #(
  parameter int unsigned CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mhpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mhpq_pkg::*;

  logic [RESULT_W-1:0] rsp_result;
  logic [STATUS_W-1:0] rsp_status;
  logic [COUNT_W-1:0]  rsp_count;

  assign rsp_result = m_axis_tdata[OUT_STATUS_LSB-1:OUT_RESULT_LSB];
  assign rsp_status = m_axis_tdata[OUT_COUNT_LSB-1:OUT_STATUS_LSB];
  assign rsp_count  = m_axis_tdata[OUT_FIELDS_W-1:OUT_COUNT_LSB];

  // Once a request is taken, s_axis_tready drops until the sequencer is idle again.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one is still in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(rsp_count) <= CAPACITY))
    else $error("entry count above capacity");

  // Only a successful peek or remove carries a value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (rsp_status != ST_OK) |-> (rsp_result == '0))
    else $error("error response carries a nonzero value");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (rsp_status == ST_EMPTY) |-> (rsp_count == '0))
    else $error("empty status with entries held");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled response changed");

endmodule

bind max_heap_priority_queue_core mhpq_checker #(
  .CAPACITY(CAPACITY)
) u_mhpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
